// File: hw/rtl/bgs_pkg.sv
`default_nettype none

package bgs_pkg;

  // Default sizes of the grid and of the fixed-point format.
  localparam int MAX_COLS_DEF  = 64;
  localparam int MAX_ROWS_DEF  = 64;
  localparam int FRAC_BITS_DEF = 16;

  // One stored cell: presence mark above a 32 bit value.
  localparam int CELL_W        = 33;
  localparam int RAM_DEPTH_DEF = 1024;

  // Cycles from an accepted sample beat to the edge that takes its result.
  localparam int PIPE_LAT = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [31:0] ORIGIN_RST = 32'sd0;
  localparam logic [31:0]        SCALE_RST  = 32'h0001_0000;
  localparam logic [6:0]         COUNT_RST  = 7'd64;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_ORIGIN   = 3'd0,
    CFG_Y_ORIGIN   = 3'd1,
    CFG_X_SCALE    = 3'd2,
    CFG_Y_SCALE    = 3'd3,
    CFG_COLS_IN_USE = 3'd4,
    CFG_ROWS_IN_USE = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  // Control that travels with a beat leaving the mapping stages.
  typedef struct packed {
    logic valid;
    logic is_write;
    logic outside;
  } map_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/bgs_ram.sv
`default_nettype none

module bgs_ram #(
  parameter int WIDTH = bgs_pkg::CELL_W,
  parameter int DEPTH = bgs_pkg::RAM_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: hw/rtl/bgs_map.sv
`default_nettype none

module bgs_map #(
  parameter int MAX_COLS  = bgs_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS  = bgs_pkg::MAX_ROWS_DEF,
  parameter int FRAC_BITS = bgs_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic signed [31:0]          cfg_x_origin,
  input  logic signed [31:0]          cfg_y_origin,
  input  logic [31:0]                 cfg_x_scale,
  input  logic [31:0]                 cfg_y_scale,
  input  logic [6:0]                  cfg_cols,
  input  logic [6:0]                  cfg_rows,
  input  logic                        accept,
  input  logic                        func,
  input  logic [5:0]                  cell_row,
  input  logic [5:0]                  cell_col,
  input  logic signed [31:0]          cell_value,
  input  logic                        cell_present,
  input  logic signed [31:0]          point_x,
  input  logic signed [31:0]          point_y,
  output bgs_pkg::map_ctl_t           ctl,
  output logic [$clog2(MAX_COLS)-1:0] col_idx,
  output logic [$clog2(MAX_ROWS)-1:0] row_idx,
  output logic [FRAC_BITS:0]          frac_x,
  output logic [FRAC_BITS:0]          frac_y,
  output logic [5:0]                  wr_row,
  output logic [5:0]                  wr_col,
  output logic signed [31:0]          wr_value,
  output logic                        wr_present
);

  import bgs_pkg::*;

  localparam int NXW = $clog2(MAX_COLS + 1);
  localparam int NYW = $clog2(MAX_ROWS + 1);
  localparam int IXW = $clog2(MAX_COLS);
  localparam int IYW = $clog2(MAX_ROWS);
  localparam int FW  = FRAC_BITS + 2;

  logic [NXW-1:0] nx;
  logic [NYW-1:0] ny;

  // Stage 1: offsets from the origin.
  logic                v1_r, w1_r;
  logic signed [32:0]  dx1_r, dy1_r, dx1_nxt, dy1_nxt;
  logic [5:0]          row1_r, col1_r;
  logic signed [31:0]  val1_r;
  logic                pres1_r;

  // Stage 2: offsets scaled to fractional indices.
  logic                v2_r, w2_r;
  logic [63:0]         px2_r, py2_r, px2_nxt, py2_nxt;
  logic                nx2_r, ny2_r;
  logic [5:0]          row2_r, col2_r;
  logic signed [31:0]  val2_r;
  logic                pres2_r;

  // Stage 3: clamped indices and weights.
  map_ctl_t            ctl3_r, ctl3_nxt;
  logic [IXW-1:0]      ix3_r, ix3_nxt;
  logic [IYW-1:0]      iy3_r, iy3_nxt;
  logic [FRAC_BITS:0]  fx3_r, fx3_nxt, fy3_r, fy3_nxt;
  logic [5:0]          row3_r, col3_r;
  logic signed [31:0]  val3_r;
  logic                pres3_r;

  logic [63:0]         lim_x, lim_y, flx, fly;
  logic [FW-1:0]       fx_full, fy_full;
  logic                out_x, out_y;

  // A zero count behaves as one; counts beyond the store saturate.
  always_comb begin
    if (cfg_cols == '0) begin
      nx = NXW'(1);
    end else if (32'(cfg_cols) > 32'(MAX_COLS)) begin
      nx = NXW'(MAX_COLS);
    end else begin
      nx = NXW'(cfg_cols);
    end
    if (cfg_rows == '0) begin
      ny = NYW'(1);
    end else if (32'(cfg_rows) > 32'(MAX_ROWS)) begin
      ny = NYW'(MAX_ROWS);
    end else begin
      ny = NYW'(cfg_rows);
    end
  end

  assign dx1_nxt = 33'(point_x) - 33'(cfg_x_origin);
  assign dy1_nxt = 33'(point_y) - 33'(cfg_y_origin);

  // A negative offset lies outside unless the scale folds every point onto zero.
  assign px2_nxt = dx1_r[32] ? 64'd0 : (64'(dx1_r[31:0]) * 64'(cfg_x_scale));
  assign py2_nxt = dy1_r[32] ? 64'd0 : (64'(dy1_r[31:0]) * 64'(cfg_y_scale));

  always_comb begin
    lim_x   = 64'(nx - NXW'(1)) << (2 * FRAC_BITS);
    lim_y   = 64'(ny - NYW'(1)) << (2 * FRAC_BITS);
    flx     = px2_r >> (2 * FRAC_BITS);
    fly     = py2_r >> (2 * FRAC_BITS);
    ix3_nxt = '0;
    iy3_nxt = '0;
    fx3_nxt = '0;
    fy3_nxt = '0;
    fx_full = '0;
    fy_full = '0;
    out_x   = 1'b0;
    out_y   = 1'b0;
    // With a single column or row the axis never lies outside and has no weight.
    if (nx > NXW'(1)) begin
      out_x = nx2_r || (px2_r > lim_x);
      if (flx > 64'(nx - NXW'(2))) begin
        ix3_nxt = IXW'(nx - NXW'(2));
      end else begin
        ix3_nxt = IXW'(flx);
      end
      fx_full = px2_r[2*FRAC_BITS+1:FRAC_BITS] - (FW'(ix3_nxt) << FRAC_BITS);
      fx3_nxt = fx_full[FRAC_BITS:0];
    end
    if (ny > NYW'(1)) begin
      out_y = ny2_r || (py2_r > lim_y);
      if (fly > 64'(ny - NYW'(2))) begin
        iy3_nxt = IYW'(ny - NYW'(2));
      end else begin
        iy3_nxt = IYW'(fly);
      end
      fy_full = py2_r[2*FRAC_BITS+1:FRAC_BITS] - (FW'(iy3_nxt) << FRAC_BITS);
      fy3_nxt = fy_full[FRAC_BITS:0];
    end
    ctl3_nxt.valid    = v2_r;
    ctl3_nxt.is_write = w2_r;
    ctl3_nxt.outside  = out_x || out_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      ctl3_r <= '0;
    end else begin
      v1_r   <= accept;
      v2_r   <= v1_r;
      ctl3_r <= ctl3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w1_r    <= (func == FUNC_WRITE);
    dx1_r   <= dx1_nxt;
    dy1_r   <= dy1_nxt;
    row1_r  <= cell_row;
    col1_r  <= cell_col;
    val1_r  <= cell_value;
    pres1_r <= cell_present;

    w2_r    <= w1_r;
    px2_r   <= px2_nxt;
    py2_r   <= py2_nxt;
    nx2_r   <= dx1_r[32] && (cfg_x_scale != '0);
    ny2_r   <= dy1_r[32] && (cfg_y_scale != '0);
    row2_r  <= row1_r;
    col2_r  <= col1_r;
    val2_r  <= val1_r;
    pres2_r <= pres1_r;

    ix3_r   <= ix3_nxt;
    iy3_r   <= iy3_nxt;
    fx3_r   <= fx3_nxt;
    fy3_r   <= fy3_nxt;
    row3_r  <= row2_r;
    col3_r  <= col2_r;
    val3_r  <= val2_r;
    pres3_r <= pres2_r;
  end

  assign ctl        = ctl3_r;
  assign col_idx    = ix3_r;
  assign row_idx    = iy3_r;
  assign frac_x     = fx3_r;
  assign frac_y     = fy3_r;
  assign wr_row     = row3_r;
  assign wr_col     = col3_r;
  assign wr_value   = val3_r;
  assign wr_present = pres3_r;

endmodule

`default_nettype wire

// File: hw/rtl/bgs_store.sv
`default_nettype none

module bgs_store #(
  parameter int MAX_COLS = bgs_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = bgs_pkg::MAX_ROWS_DEF
) (
  input  logic                        clk,
  input  bgs_pkg::map_ctl_t           ctl,
  input  logic [$clog2(MAX_COLS)-1:0] col_idx,
  input  logic [$clog2(MAX_ROWS)-1:0] row_idx,
  input  logic [5:0]                  wr_row,
  input  logic [5:0]                  wr_col,
  input  logic signed [31:0]          wr_value,
  input  logic                        wr_present,
  output logic signed [31:0]          cell_val [4],
  output logic [3:0]                  cell_ok
);

  import bgs_pkg::*;

  localparam int IXW = $clog2(MAX_COLS);
  localparam int IYW = $clog2(MAX_ROWS);
  localparam int RHW = ($clog2((MAX_ROWS + 1) / 2) > 0) ? $clog2((MAX_ROWS + 1) / 2) : 1;
  localparam int CHW = ($clog2((MAX_COLS + 1) / 2) > 0) ? $clog2((MAX_COLS + 1) / 2) : 1;
  localparam int BAW = RHW + CHW;
  localparam int BANK_DEPTH = 1 << BAW;

  // The grid is split into four banks by row and column parity, so the four
  // corners of any cell square sit in four different banks.
  logic [CELL_W-1:0] bank_q [4];
  logic              wr_in_range;
  logic [1:0]        wr_bank;
  logic [BAW-1:0]    wr_addr;
  logic              jp_r, ip_r;

  assign wr_in_range = (32'(wr_row) < 32'(MAX_ROWS)) && (32'(wr_col) < 32'(MAX_COLS));
  assign wr_bank     = {wr_row[0], wr_col[0]};
  assign wr_addr     = {RHW'(wr_row >> 1), CHW'(wr_col >> 1)};

  for (genvar g = 0; g < 4; g++) begin : g_bank
    localparam logic RP = 1'((g >> 1) & 1);
    localparam logic CP = 1'(g & 1);
    logic [IYW-1:0] rsel;
    logic [IXW-1:0] csel;
    logic [BAW-1:0] addr;
    logic           we;

    assign rsel = (row_idx[0] == RP) ? row_idx : row_idx + IYW'(1);
    assign csel = (col_idx[0] == CP) ? col_idx : col_idx + IXW'(1);
    assign we   = ctl.valid && ctl.is_write && wr_in_range && (wr_bank == 2'(g));
    assign addr = ctl.is_write ? wr_addr : {RHW'(rsel >> 1), CHW'(csel >> 1)};

    bgs_ram #(
      .WIDTH (CELL_W),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (we),
      .addr  (addr),
      .wdata ({wr_present, wr_value}),
      .rdata (bank_q[g])
    );
  end

  always_ff @(posedge clk) begin
    jp_r <= row_idx[0];
    ip_r <= col_idx[0];
  end

  // Corner k sits in the bank whose parities differ from the base corner by k.
  always_comb begin
    logic [1:0] sel;
    for (int k = 0; k < 4; k++) begin
      sel         = {jp_r, ip_r} ^ 2'(k);
      cell_val[k] = bank_q[sel][31:0];
      cell_ok[k]  = bank_q[sel][32];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bgs_blend.sv
`default_nettype none

module bgs_blend #(
  parameter int FRAC_BITS = bgs_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bgs_pkg::map_ctl_t  ctl,
  input  logic [FRAC_BITS:0] frac_x,
  input  logic [FRAC_BITS:0] frac_y,
  input  logic signed [31:0] cell_val [4],
  input  logic [3:0]         cell_ok,
  output logic               out_strobe,
  output logic signed [31:0] out_value,
  output logic [1:0]         out_status
);

  import bgs_pkg::*;

  localparam int WW = FRAC_BITS + 1;
  localparam int PW = 32 + FRAC_BITS + 2;
  localparam int SW = PW + 1;
  localparam logic [WW-1:0]        ONE  = WW'(1) << FRAC_BITS;
  localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] V_MAX = SW'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [SW-1:0] V_MIN = SW'(64'shFFFF_FFFF_8000_0000);

  // Stage 4 lines up with the cell data coming out of the banks.
  logic           v4_r, out4_r;
  logic [WW-1:0]  a4_r, b4_r;

  logic                  v5_r;
  status_t               st5_r, st5_nxt;
  logic signed [PW-1:0]  m5_r [4];
  logic signed [PW-1:0]  m5_nxt [4];
  logic [WW-1:0]         b5_r;

  logic                  v6_r;
  status_t               st6_r;
  logic signed [31:0]    r6_r [2];
  logic signed [31:0]    r6_nxt [2];
  logic signed [SW-1:0]  s6 [2];
  logic [WW-1:0]         b6_r;

  logic                  v7_r;
  status_t               st7_r;
  logic signed [PW-1:0]  n7_r [2];
  logic signed [PW-1:0]  n7_nxt [2];

  logic                  strobe_r;
  status_t               status_r;
  logic signed [31:0]    value_r, value_nxt;
  logic signed [SW-1:0]  t8, v8;

  logic signed [WW:0]    wna, wa, wnb, wb;
  logic [3:0]            wt;
  logic                  missing;

  assign wna = $signed({1'b0, ONE - a4_r});
  assign wa  = $signed({1'b0, a4_r});
  assign wnb = $signed({1'b0, ONE - b6_r});
  assign wb  = $signed({1'b0, b6_r});

  // A missing cell only matters when it carries some weight.
  always_comb begin
    wt[0]   = (a4_r != ONE) && (b4_r != ONE);
    wt[1]   = (a4_r != '0)  && (b4_r != ONE);
    wt[2]   = (a4_r != ONE) && (b4_r != '0);
    wt[3]   = (a4_r != '0)  && (b4_r != '0);
    missing = |(wt & ~cell_ok);
    if (out4_r) begin
      st5_nxt = ST_OUTSIDE;
    end else if (missing) begin
      st5_nxt = ST_MISSING;
    end else begin
      st5_nxt = ST_OK;
    end
    m5_nxt[0] = cell_val[0] * wna;
    m5_nxt[1] = cell_val[1] * wa;
    m5_nxt[2] = cell_val[2] * wna;
    m5_nxt[3] = cell_val[3] * wa;
  end

  // Rounding adds one half and shifts arithmetically, so ties go upward.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      s6[k]     = SW'(m5_r[2*k]) + SW'(m5_r[2*k+1]) + HALF;
      r6_nxt[k] = 32'(s6[k] >>> FRAC_BITS);
    end
    n7_nxt[0] = r6_r[0] * wnb;
    n7_nxt[1] = r6_r[1] * wb;
  end

  always_comb begin
    t8 = SW'(n7_r[0]) + SW'(n7_r[1]) + HALF;
    v8 = t8 >>> FRAC_BITS;
    if (st7_r != ST_OK) begin
      value_nxt = '0;
    end else if (v8 > V_MAX) begin
      value_nxt = 32'sh7FFF_FFFF;
    end else if (v8 < V_MIN) begin
      value_nxt = 32'sh8000_0000;
    end else begin
      value_nxt = 32'(v8);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r     <= 1'b0;
      v5_r     <= 1'b0;
      v6_r     <= 1'b0;
      v7_r     <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      v4_r     <= ctl.valid && !ctl.is_write;
      v5_r     <= v4_r;
      v6_r     <= v5_r;
      v7_r     <= v6_r;
      strobe_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    out4_r   <= ctl.outside;
    a4_r     <= frac_x;
    b4_r     <= frac_y;
    st5_r    <= st5_nxt;
    m5_r     <= m5_nxt;
    b5_r     <= b4_r;
    st6_r    <= st5_r;
    r6_r     <= r6_nxt;
    b6_r     <= b5_r;
    st7_r    <= st6_r;
    n7_r     <= n7_nxt;
    status_r <= st7_r;
    value_r  <= value_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_value  = value_r;
  assign out_status = status_r;

endmodule

`default_nettype wire

// File: hw/rtl/bilinear_grid_sampler.sv
`default_nettype none

// Channel   Handshake             Payload
// input     start / busy          in_func, in_cell_row, in_cell_col, in_cell_value,
//                                 in_cell_present, in_point_x, in_point_y
// result    out_strobe            out_sample_value, out_status
// config    cfg_we                cfg_index, cfg_wdata
//
// One beat is taken every cycle; busy stays low. A sample beat's result passes
// through three mapping stages, the banked cell read and the blend stages.
// A cell write reaches its bank after the three mapping stages, in the same
// slot where samples read, so order is kept. Reset is synchronous; it clears the
// pipeline valid bits and sets the registers to their reset values; cell contents
// are undefined until written. The receiver cannot stall the result strobe.
module bilinear_grid_sampler #(
  parameter int MAX_COLS  = bgs_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS  = bgs_pkg::MAX_ROWS_DEF,
  parameter int FRAC_BITS = bgs_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_func,
  input  logic [5:0]                       in_cell_row,
  input  logic [5:0]                       in_cell_col,
  input  logic signed [31:0]               in_cell_value,
  input  logic                             in_cell_present,
  input  logic signed [31:0]               in_point_x,
  input  logic signed [31:0]               in_point_y,
  output logic                             out_strobe,
  output logic signed [31:0]               out_sample_value,
  output logic [1:0]                       out_status,
  input  logic                             cfg_we,
  input  logic [bgs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bgs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import bgs_pkg::*;

  localparam int IXW = $clog2(MAX_COLS);
  localparam int IYW = $clog2(MAX_ROWS);

  logic signed [31:0] x_origin_r, y_origin_r;
  logic [31:0]        x_scale_r, y_scale_r;
  logic [6:0]         cols_r, rows_r;

  map_ctl_t            map_ctl;
  logic [IXW-1:0]      col_idx;
  logic [IYW-1:0]      row_idx;
  logic [FRAC_BITS:0]  frac_x, frac_y;
  logic [5:0]          wr_row, wr_col;
  logic signed [31:0]  wr_value;
  logic                wr_present;
  logic signed [31:0]  cell_val [4];
  logic [3:0]          cell_ok;
  logic                accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_origin_r <= ORIGIN_RST;
      y_origin_r <= ORIGIN_RST;
      x_scale_r  <= SCALE_RST;
      y_scale_r  <= SCALE_RST;
      cols_r     <= COUNT_RST;
      rows_r     <= COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_X_ORIGIN:    x_origin_r <= $signed(cfg_wdata[31:0]);
        CFG_Y_ORIGIN:    y_origin_r <= $signed(cfg_wdata[31:0]);
        CFG_X_SCALE:     x_scale_r  <= cfg_wdata[31:0];
        CFG_Y_SCALE:     y_scale_r  <= cfg_wdata[31:0];
        CFG_COLS_IN_USE: cols_r     <= cfg_wdata[6:0];
        CFG_ROWS_IN_USE: rows_r     <= cfg_wdata[6:0];
        default: begin
        end
      endcase
    end
  end

  bgs_map #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .FRAC_BITS (FRAC_BITS)
  ) u_map (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_x_origin (x_origin_r),
    .cfg_y_origin (y_origin_r),
    .cfg_x_scale  (x_scale_r),
    .cfg_y_scale  (y_scale_r),
    .cfg_cols     (cols_r),
    .cfg_rows     (rows_r),
    .accept       (accept),
    .func         (in_func),
    .cell_row     (in_cell_row),
    .cell_col     (in_cell_col),
    .cell_value   (in_cell_value),
    .cell_present (in_cell_present),
    .point_x      (in_point_x),
    .point_y      (in_point_y),
    .ctl          (map_ctl),
    .col_idx      (col_idx),
    .row_idx      (row_idx),
    .frac_x       (frac_x),
    .frac_y       (frac_y),
    .wr_row       (wr_row),
    .wr_col       (wr_col),
    .wr_value     (wr_value),
    .wr_present   (wr_present)
  );

  bgs_store #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_store (
    .clk        (clk),
    .ctl        (map_ctl),
    .col_idx    (col_idx),
    .row_idx    (row_idx),
    .wr_row     (wr_row),
    .wr_col     (wr_col),
    .wr_value   (wr_value),
    .wr_present (wr_present),
    .cell_val   (cell_val),
    .cell_ok    (cell_ok)
  );

  bgs_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (map_ctl),
    .frac_x     (frac_x),
    .frac_y     (frac_y),
    .cell_val   (cell_val),
    .cell_ok    (cell_ok),
    .out_strobe (out_strobe),
    .out_value  (out_sample_value),
    .out_status (out_status)
  );

`ifndef SYNTHESIS
  a_sample_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == FUNC_SAMPLE) |-> ##PIPE_LAT out_strobe)
    else $error("sample beat produced no result strobe");

  a_result_has_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept && in_func == FUNC_SAMPLE, PIPE_LAT))
    else $error("result strobe without a matching sample beat");

  a_bad_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != ST_OK) |-> (out_sample_value == '0))
    else $error("non-zero value with a failing status");
`endif

endmodule

`default_nettype wire

// File: verif/bilinear_grid_sampler_tb.sv
`timescale 1ns / 1ps

module bilinear_grid_sampler_tb;
  import bgs_pkg::*;

  localparam int FB          = FRAC_BITS_DEF;
  localparam int CELLS       = MAX_ROWS_DEF * MAX_COLS_DEF;
  localparam int CYCLE_LIMIT = 400000;

  // Register slots above the six defined ones; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef longint unsigned u64_t;

  typedef struct {
    logic               func;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] value;
    logic               present;
    logic signed [31:0] px;
    logic signed [31:0] py;
  } beat_t;

  typedef struct {
    logic signed [31:0] value;
    status_t            status;
  } sample_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_func = FUNC_WRITE;
  logic [5:0]            in_cell_row = '0;
  logic [5:0]            in_cell_col = '0;
  logic signed [31:0]    in_cell_value = '0;
  logic                  in_cell_present = 1'b0;
  logic signed [31:0]    in_point_x = '0;
  logic signed [31:0]    in_point_y = '0;
  logic                  out_strobe;
  logic signed [31:0]    out_sample_value;
  logic [1:0]            out_status;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  bilinear_grid_sampler uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_cell_row      (in_cell_row),
    .in_cell_col      (in_cell_col),
    .in_cell_value    (in_cell_value),
    .in_cell_present  (in_cell_present),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .out_strobe       (out_strobe),
    .out_sample_value (out_sample_value),
    .out_status       (out_status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mirror of the cell store and of the registers.
  logic signed [31:0] cell_val [0:CELLS-1];
  logic               cell_here [0:CELLS-1];
  // Cells that some queued write has already loaded.
  bit                 cell_seen [0:CELLS-1];
  logic signed [31:0] x_org = ORIGIN_RST;
  logic signed [31:0] y_org = ORIGIN_RST;
  logic [31:0]        x_scl = SCALE_RST;
  logic [31:0]        y_scl = SCALE_RST;
  logic [6:0]         cols_reg = COUNT_RST;
  logic [6:0]         rows_reg = COUNT_RST;

  beat_t   beats_pending [$];
  sample_t samples_due [$];
  beat_t   beat_now;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  function automatic int unsigned eff_count(logic [6:0] r, int unsigned maxv);
    if (r == 0) return 1;
    if (r > maxv) return maxv;
    return r;
  endfunction

  // Maps one coordinate onto its axis; returns 0 when the point lies outside.
  function automatic bit map_axis(input logic signed [31:0] p, input logic signed [31:0] org,
                                  input logic [31:0] scl, input int unsigned n,
                                  output int unsigned idx, output longint frac);
    longint d;
    u64_t prod, whole;
    idx = 0;
    frac = 0;
    if (n <= 1) return 1'b1;
    d = longint'(p) - longint'(org);
    if (d < 0) begin
      if (scl != 0) return 1'b0;
      prod = 0;
    end else begin
      prod = u64_t'(d) * u64_t'(scl);
    end
    if (prod > (u64_t'(n - 1) << (2 * FB))) return 1'b0;
    whole = prod >> (2 * FB);
    idx = (whole > u64_t'(n - 2)) ? n - 2 : int'(whole);
    frac = longint'(prod >> FB) - (longint'(idx) << FB);
    return 1'b1;
  endfunction

  // Drops FB fraction bits, halves rounding upwards.
  function automatic longint round_q(longint v);
    return (v + (longint'(1) <<< (FB - 1))) >>> FB;
  endfunction

  function automatic sample_t predict_sample(logic signed [31:0] px, logic signed [31:0] py);
    sample_t res;
    int unsigned nx, ny, i0, i1, j0, j1;
    longint one, a, b, r0, r1, v;
    longint c [4];
    int unsigned addr [4];
    bit heavy [4];
    bit gap_cell;
    one = longint'(1) << FB;
    res.value = '0;
    res.status = ST_OK;
    nx = eff_count(cols_reg, MAX_COLS_DEF);
    ny = eff_count(rows_reg, MAX_ROWS_DEF);
    if (!map_axis(px, x_org, x_scl, nx, i0, a) || !map_axis(py, y_org, y_scl, ny, j0, b)) begin
      res.status = ST_OUTSIDE;
      return res;
    end
    i1 = (nx > 1) ? i0 + 1 : i0;
    j1 = (ny > 1) ? j0 + 1 : j0;
    addr[0] = j0 * MAX_COLS_DEF + i0;
    addr[1] = j0 * MAX_COLS_DEF + i1;
    addr[2] = j1 * MAX_COLS_DEF + i0;
    addr[3] = j1 * MAX_COLS_DEF + i1;
    heavy[0] = (a != one) && (b != one);
    heavy[1] = (a != 0) && (b != one);
    heavy[2] = (a != one) && (b != 0);
    heavy[3] = (a != 0) && (b != 0);
    gap_cell = 1'b0;
    for (int k = 0; k < 4; k++) begin
      c[k] = cell_val[addr[k]];
      if (heavy[k] && !cell_here[addr[k]]) gap_cell = 1'b1;
    end
    if (gap_cell) begin
      res.status = ST_MISSING;
      return res;
    end
    r0 = round_q(c[0] * (one - a) + c[1] * a);
    r1 = round_q(c[2] * (one - a) + c[3] * a);
    v = round_q(r0 * (one - b) + r1 * b);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    res.value = v[31:0];
    return res;
  endfunction

  task automatic apply_beat(beat_t b);
    if (b.func == FUNC_WRITE) begin
      cell_val[b.row * MAX_COLS_DEF + b.col] = b.value;
      cell_here[b.row * MAX_COLS_DEF + b.col] = b.present;
    end else begin
      samples_due.insert(samples_due.size(), predict_sample(b.px, b.py));
    end
  endtask

  task automatic flag_mismatch(string what);
    $display("MISMATCH cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Driver: one beat on the port at a time, with a drawn number of idle cycles after each.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        apply_beat(beat_now);
        if (burst_left > 0) begin
          gap_left = 0;
          burst_left--;
        end else begin
          gap_left = $urandom_range(0, 9);
          if ($urandom_range(0, 29) == 0) burst_left = $urandom_range(10, 40);
        end
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          start <= 1'b0;
          gap_left--;
        end else if (beats_pending.size() > 0) begin
          beat_now = beats_pending.pop_front();
          in_func <= beat_now.func;
          in_cell_row <= beat_now.row;
          in_cell_col <= beat_now.col;
          in_cell_value <= beat_now.value;
          in_cell_present <= beat_now.present;
          in_point_x <= beat_now.px;
          in_point_y <= beat_now.py;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    sample_t due;
    if (rst_n && out_strobe) begin
      if (samples_due.size() == 0) begin
        flag_mismatch("result strobe with no sample outstanding");
      end else begin
        due = samples_due.pop_front();
        if (out_status !== due.status)
          flag_mismatch($sformatf("status %0d, expected %s", out_status, due.status.name()));
        if (out_sample_value !== due.value)
          flag_mismatch($sformatf("value %h, expected %h", out_sample_value, due.value));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples outstanding", cycle_count,
               samples_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      default: return $urandom;
    endcase
  endfunction

  // A coordinate aimed at the grid: a chosen fractional index turned back into a point,
  // sometimes nudged by one step so that edges and exact cell lines are crossed.
  function automatic logic [31:0] aim_point(logic signed [31:0] org, logic [31:0] scl,
                                            int unsigned n);
    u64_t f16, d;
    int unsigned pick;
    if (n <= 1 || scl == 0) return $urandom;
    pick = $urandom_range(0, 9);
    case (pick)
      0: f16 = 0;
      1: f16 = u64_t'(n - 1) << FB;
      2: f16 = u64_t'($urandom_range(0, n - 1)) << FB;
      default: f16 = u64_t'($urandom) % ((u64_t'(n - 1) << FB) + 1);
    endcase
    d = (f16 << FB) / scl;
    if (pick < 3) d = d + $urandom_range(0, 2) - 1;
    return org + d[31:0];
  endfunction

  task automatic queue_write(int unsigned row, int unsigned col, logic [31:0] value,
                             bit present);
    beat_t b;
    b.func = FUNC_WRITE;
    b.row = 6'(row);
    b.col = 6'(col);
    b.value = value;
    b.present = present;
    b.px = $urandom;
    b.py = $urandom;
    cell_seen[row * MAX_COLS_DEF + col] = 1'b1;
    beats_pending.insert(beats_pending.size(), b);
  endtask

  task automatic queue_sample(logic [31:0] px, logic [31:0] py);
    beat_t b;
    int unsigned i0, j0;
    longint fa, fb;
    // The square of cells around an inside point is loaded first where never written.
    if (map_axis(px, x_org, x_scl, eff_count(cols_reg, MAX_COLS_DEF), i0, fa) &&
        map_axis(py, y_org, y_scl, eff_count(rows_reg, MAX_ROWS_DEF), j0, fb)) begin
      for (int dr = 0; dr < 2; dr++)
        for (int dc = 0; dc < 2; dc++)
          if (!cell_seen[(j0 + dr) * MAX_COLS_DEF + i0 + dc])
            queue_write(j0 + dr, i0 + dc, rand_value(), $urandom_range(0, 9) != 0);
    end
    b.func = FUNC_SAMPLE;
    b.row = 6'($urandom);
    b.col = 6'($urandom);
    b.value = $urandom;
    b.present = 1'($urandom);
    b.px = px;
    b.py = py;
    beats_pending.insert(beats_pending.size(), b);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (beats_pending.size() != 0 || start || samples_due.size() != 0);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  task automatic load_config(logic [31:0] xo, logic [31:0] yo, logic [31:0] xs,
                             logic [31:0] ys, logic [6:0] nc, logic [6:0] nr,
                             bit also_spare);
    wait_drained();
    // Cell writes give no result, so allow the pipeline to empty before touching registers.
    repeat (PIPE_LAT + 4) @(posedge clk);
    x_org = xo;
    y_org = yo;
    x_scl = xs;
    y_scl = ys;
    cols_reg = nc;
    rows_reg = nr;
    put_reg(CFG_X_ORIGIN, xo);
    put_reg(CFG_Y_ORIGIN, yo);
    put_reg(CFG_X_SCALE, xs);
    put_reg(CFG_Y_SCALE, ys);
    put_reg(CFG_COLS_IN_USE, {25'd0, nc});
    put_reg(CFG_ROWS_IN_USE, {25'd0, nr});
    if (also_spare) begin
      put_reg(CFG_SPARE_LO, $urandom);
      put_reg(CFG_SPARE_HI, $urandom);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int count);
    int unsigned nx, ny, pick;
    nx = eff_count(cols_reg, MAX_COLS_DEF);
    ny = eff_count(rows_reg, MAX_ROWS_DEF);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        if ($urandom_range(0, 3) != 0)
          queue_write($urandom_range(0, ny - 1), $urandom_range(0, nx - 1), rand_value(),
                      $urandom_range(0, 7) != 0);
        else
          queue_write($urandom_range(0, 63), $urandom_range(0, 63), rand_value(),
                      $urandom_range(0, 7) != 0);
      end else if (pick < 75) begin
        queue_sample(aim_point(x_org, x_scl, nx), aim_point(y_org, y_scl, ny));
      end else if (pick < 82) begin
        queue_sample(aim_point(x_org, x_scl, nx), $urandom);
      end else if (pick < 89) begin
        queue_sample($urandom, aim_point(y_org, y_scl, ny));
      end else begin
        queue_sample($urandom, $urandom);
      end
    end
  endtask

  initial begin
    logic [6:0] nc, nr;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Extreme values blended against each other.
    queue_write(0, 0, 32'h7FFF_FFFF, 1'b1);
    queue_write(0, 1, 32'h8000_0000, 1'b1);
    queue_write(1, 0, 32'h8000_0000, 1'b1);
    queue_write(1, 1, 32'h7FFF_FFFF, 1'b1);
    queue_sample(32'h0000_0000, 32'h0000_0000);
    queue_sample(32'h0000_8000, 32'h0000_0000);
    queue_sample(32'h0000_8000, 32'h0000_8000);
    queue_sample(32'h0000_4000, 32'h0000_C000);
    // A missing cell counts only where it carries weight; outside beats missing.
    queue_write(4, 5, rand_value(), 1'b1);
    queue_write(5, 5, rand_value(), 1'b1);
    queue_write(5, 6, rand_value(), 1'b0);
    queue_write(6, 5, rand_value(), 1'b1);
    queue_sample(32'h0005_0000, 32'h0005_0000);
    queue_sample(32'h0005_0000, 32'h0004_8000);
    queue_sample(32'h0005_8000, 32'h0005_0000);
    queue_sample(32'h0005_8000, 32'h0040_0000);
    queue_sample(32'hFFFF_FFFF, 32'h0005_0000);
    // Far edge of the grid, one step beyond it, and the coordinate extremes.
    queue_sample(32'h003F_0000, 32'h003F_0000);
    queue_sample(32'h003F_0001, 32'h0000_0000);
    queue_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_sample(32'h8000_0000, 32'h8000_0000);
    run_random(90);

    // Column count above the store size saturates; a row count of zero means one row.
    load_config(32'hFFFB_0000, 32'h0000_0000, SCALE_RST, 32'h0000_0000, 7'd127, 7'd0, 1'b0);
    run_random(90);
    // One column, and a y axis at the most negative origin with the largest scale.
    load_config(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd1, 7'd64,
                1'b0);
    run_random(90);
    // Zero scale pins every x onto the first column.
    load_config(32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 32'h0002_8000, 7'd2, 7'd5, 1'b0);
    run_random(90);
    load_config(32'h8000_0000, 32'h7FC0_0000, SCALE_RST, SCALE_RST, 7'd64, 7'd64, 1'b1);
    run_random(90);
    load_config($urandom_range(0, 32'h0020_0000) - 32'h0010_0000, $urandom, 32'h0000_8000,
                32'h0000_8000, 7'd3, 7'd2, 1'b0);
    run_random(90);
    repeat (2) begin
      nc = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(1, 8));
      nr = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(1, 8));
      load_config($urandom_range(0, 32'h0020_0000) - 32'h0010_0000,
                  $urandom_range(0, 32'h0020_0000) - 32'h0010_0000,
                  $urandom_range(32'h1000, 32'h8_0000), $urandom_range(32'h1000, 32'h8_0000),
                  nc, nr, 1'b0);
      run_random(90);
    end

    wait_drained();
    repeat (2 * PIPE_LAT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
